### hw/rtl/kdmb_pkg.sv
`default_nettype none
package kdmb_pkg;

    localparam int unsigned KEY_SLOTS_DEFAULT = 4;
    localparam int unsigned MAX_SLOTS         = 8;
    localparam int unsigned WORD_SLOTS        = 4;
    localparam int unsigned CODE_W            = 8;
    localparam int unsigned WORD_W            = 32;
    localparam int unsigned STAMP_W           = 32;
    localparam int unsigned LIMIT_W           = 16;
    localparam int unsigned COUNT_W           = 17;
    localparam int unsigned PADDR_W           = 3;
    localparam int unsigned PDATA_W           = 32;

    localparam logic [COUNT_W-1:0] COUNT_STEP = COUNT_W'(10);

    // register index, taken from paddr[2]
    localparam logic REG_STABLE_LIMIT = 1'b0;

    typedef struct packed {
        logic              fire;
        logic [WORD_W-1:0] newer;
        logic [WORD_W-1:0] older;
    } scan_t;

    function automatic logic [CODE_W-1:0] slot_code(input logic [WORD_W-1:0] word,
                                                    input int unsigned slot);
        logic [WORD_W-1:0] sh;
        sh = '0;
        if (slot >= WORD_SLOTS) begin
            return '0;
        end
        sh = word >> (CODE_W * slot);
        return sh[CODE_W-1:0];
    endfunction

    function automatic logic word_holds(input logic [WORD_W-1:0] word,
                                        input logic [CODE_W-1:0] code,
                                        input int unsigned key_slots);
        logic hit;
        hit = 1'b0;
        for (int unsigned s = 0; s < MAX_SLOTS; s++) begin
            if (s < key_slots && slot_code(word, s) == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/kdmb_lane.sv
`default_nettype none
module kdmb_lane #(
    parameter int unsigned KEY_SLOTS = kdmb_pkg::KEY_SLOTS_DEFAULT,
    parameter int unsigned LANE      = 0
) (
    input  kdmb_pkg::scan_t                  scan,
    output logic [kdmb_pkg::CODE_W-1:0]      new_code,
    output logic [kdmb_pkg::CODE_W-1:0]      old_code,
    output logic                             make_hit,
    output logic                             brk_hit
);
    import kdmb_pkg::*;

    always_comb begin
        new_code = slot_code(scan.newer, LANE);
        old_code = slot_code(scan.older, LANE);
        make_hit = (new_code != '0) && !word_holds(scan.older, new_code, KEY_SLOTS);
        brk_hit  = (old_code != '0) && !word_holds(scan.newer, old_code, KEY_SLOTS);
    end

endmodule
`default_nettype wire

### hw/rtl/kdmb_debounce.sv
`default_nettype none
module kdmb_debounce (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [kdmb_pkg::WORD_W-1:0]      sample,
    input  logic [kdmb_pkg::LIMIT_W-1:0]     limit,
    output kdmb_pkg::scan_t                  scan
);
    import kdmb_pkg::*;

    logic [WORD_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  reported_reg, reported_next;
    logic [COUNT_W-1:0] limit_ext;

    always_comb begin
        limit_ext = COUNT_W'(limit);
        if (sample != held_reg) begin
            held_next  = sample;
            count_next = '0;
        end else if (count_reg < limit_ext) begin
            held_next  = held_reg;
            count_next = count_reg + COUNT_STEP;
        end else begin
            held_next  = held_reg;
            count_next = count_reg;
        end
        scan.fire     = (reported_reg != held_next) && (count_next >= limit_ext);
        scan.newer    = held_next;
        scan.older    = reported_reg;
        reported_next = scan.fire ? held_next : reported_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            count_reg    <= '0;
            reported_reg <= '0;
        end else if (accept) begin
            held_reg     <= held_next;
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_report_tracks_held: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && scan.fire |=> reported_reg == held_reg)
        else $error("reported word not taken from held sample");
    a_change_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && sample != held_reg |=> count_reg == '0)
        else $error("stability count not cleared on sample change");
`endif

endmodule
`default_nettype wire

### hw/rtl/kdmb_merge.sv
`default_nettype none
module kdmb_merge #(
    parameter int unsigned KEY_SLOTS = kdmb_pkg::KEY_SLOTS_DEFAULT,
    localparam int unsigned EV_N     = 2 * KEY_SLOTS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load,
    input  logic [EV_N-1:0]                           hits_in,
    input  logic [EV_N-1:0][kdmb_pkg::CODE_W-1:0]     codes_in,
    input  logic [kdmb_pkg::STAMP_W-1:0]              stamp_in,
    output logic                                      load_ready,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [kdmb_pkg::CODE_W-1:0]               m_key_code,
    output logic                                      m_is_break,
    output logic [kdmb_pkg::STAMP_W-1:0]              m_event_time,
    output logic                                      m_last
);
    import kdmb_pkg::*;

    localparam int unsigned IDX_W = $clog2(EV_N);

    logic [EV_N-1:0]              ev_mask_reg, ev_mask_next;
    logic [EV_N-1:0][CODE_W-1:0]  ev_code_reg;
    logic [STAMP_W-1:0]           stamp_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]            m_key_code_reg;
    logic                         m_is_break_reg;
    logic [STAMP_W-1:0]           m_event_time_reg;
    logic                         m_last_reg;

    logic [IDX_W-1:0] pick_idx;
    logic             pick_brk;
    logic             found;
    logic [EV_N-1:0]  rest_mask;
    logic             pend_any;
    logic             out_free;
    logic             pop;

    always_comb begin
        pick_idx = '0;
        pick_brk = 1'b0;
        found    = 1'b0;
        for (int unsigned i = 0; i < EV_N; i++) begin
            if (!found && ev_mask_reg[i]) begin
                pick_idx = IDX_W'(i);
                pick_brk = (i >= KEY_SLOTS);
                found    = 1'b1;
            end
        end
        rest_mask  = ev_mask_reg & ~(EV_N'(1) << pick_idx);
        pend_any   = |ev_mask_reg;
        out_free   = !m_valid_reg || m_ready;
        pop        = pend_any && out_free;
        load_ready = !pend_any || (pop && rest_mask == '0);

        if (load) begin
            ev_mask_next = hits_in;
        end else if (pop) begin
            ev_mask_next = rest_mask;
        end else begin
            ev_mask_next = ev_mask_reg;
        end

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_mask_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ev_mask_reg <= ev_mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_code_reg <= codes_in;
            stamp_reg   <= stamp_in;
        end
        if (pop) begin
            m_key_code_reg   <= ev_code_reg[pick_idx];
            m_is_break_reg   <= pick_brk;
            m_event_time_reg <= stamp_reg;
            m_last_reg       <= (rest_mask == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_code   = m_key_code_reg;
    assign m_is_break   = m_is_break_reg;
    assign m_event_time = m_event_time_reg;
    assign m_last       = m_last_reg;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> load_ready)
        else $error("pending events overwritten");
    a_stall_blocks_load: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_any && !out_free |-> !load_ready)
        else $error("input taken while result path stalled");
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && rest_mask == '0 && !load |=> !pend_any && m_valid_reg && m_last_reg)
        else $error("final event did not drain pending set");
`endif

endmodule
`default_nettype wire

### hw/rtl/keyboard_debounce_make_break_unit.sv
`default_nettype none
// Keyboard debounce with make/break event output. Each input transaction is one scan tick;
// when it is taken, the debounce state updates at once and all slot lanes compare the new
// and old words in parallel. A tick producing n events (0 to 2*min(KEY_SLOTS,4)) holds the
// result side while its pending events drain through the single output register, one per
// cycle unless m_ready stalls the output, so the next tick is accepted in the cycle the previous
// tick's last event moves into that register, or immediately when a tick makes no events.
// stable_limit lives at byte address 0; a read there returns it.
module keyboard_debounce_make_break_unit #(
    parameter int unsigned KEY_SLOTS = kdmb_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kdmb_pkg::PADDR_W-1:0]      paddr,
    input  logic [kdmb_pkg::PDATA_W-1:0]      pwdata,
    output logic [kdmb_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kdmb_pkg::WORD_W-1:0]       s_key_sample,
    input  logic [kdmb_pkg::STAMP_W-1:0]      s_timestamp,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kdmb_pkg::CODE_W-1:0]       m_key_code,
    output logic                              m_is_break,
    output logic [kdmb_pkg::STAMP_W-1:0]      m_event_time,
    output logic                              m_last
);
    import kdmb_pkg::*;

    localparam int unsigned EV_N = 2 * KEY_SLOTS;

    logic [LIMIT_W-1:0]          limit_reg;
    scan_t                       scan;
    logic                        accept;
    logic                        load;
    logic                        load_ready;
    logic [EV_N-1:0]             hits;
    logic [EV_N-1:0][CODE_W-1:0] codes;

    // config register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_STABLE_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == '0) begin
            prdata = PDATA_W'(limit_reg);
        end else begin
            prdata = '0;
        end
    end

    assign s_ready = load_ready;
    assign accept  = s_valid && s_ready;
    assign load    = accept && scan.fire && (|hits);

    kdmb_debounce u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .sample  (s_key_sample),
        .limit   (limit_reg),
        .scan    (scan)
    );

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        kdmb_lane #(
            .KEY_SLOTS (KEY_SLOTS),
            .LANE      (g)
        ) u_lane (
            .scan     (scan),
            .new_code (codes[g]),
            .old_code (codes[KEY_SLOTS + g]),
            .make_hit (hits[g]),
            .brk_hit  (hits[KEY_SLOTS + g])
        );
    end

    kdmb_merge #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .hits_in      (hits),
        .codes_in     (codes),
        .stamp_in     (s_timestamp),
        .load_ready   (load_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_code   (m_key_code),
        .m_is_break   (m_is_break),
        .m_event_time (m_event_time),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire

### sim/keyboard_debounce_make_break_unit_tb.sv
`default_nettype none
module keyboard_debounce_make_break_unit_tb;
    import kdmb_pkg::*;

    localparam int unsigned SLOTS        = KEY_SLOTS_DEFAULT;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned HOLD_AFTER   = 80;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 12;
    localparam int unsigned NUM_PHASES   = 8;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_STABLE_LIMIT, 2'b00};
    // debounce limit per random phase, phase 0 in the low bits
    localparam logic [NUM_PHASES*LIMIT_W-1:0] PHASE_LIMITS = {
        16'd25, 16'd0, 16'd50, 16'd9, 16'hffff, 16'd30, 16'd0, 16'd10
    };

    typedef struct packed {
        logic [WORD_W-1:0]  sample;
        logic [STAMP_W-1:0] stamp;
    } scan_tick_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               brk;
        logic [STAMP_W-1:0] stamp;
        logic               fin;
    } key_event_t;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [PADDR_W-1:0]   paddr        = '0;
    logic [PDATA_W-1:0]   pwdata       = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_key_sample = '0;
    logic [STAMP_W-1:0]   s_timestamp  = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [CODE_W-1:0]    m_key_code;
    logic                 m_is_break;
    logic [STAMP_W-1:0]   m_event_time;
    logic                 m_last;

    scan_tick_t  scan_q[$];
    key_event_t  event_q[$];

    // debounce state mirror
    logic [WORD_W-1:0]  held_word  = '0;
    logic [COUNT_W-1:0] stable_cnt = '0;
    logic [WORD_W-1:0]  shown_word = '0;
    logic [LIMIT_W-1:0] limit_reg  = '0;

    bit          s_fire       = 1'b0;
    bit          m_fire       = 1'b0;
    bit          steady       = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned ticks_taken  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned errors       = 0;

    keyboard_debounce_make_break_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_sample (s_key_sample),
        .s_timestamp  (s_timestamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_code   (m_key_code),
        .m_is_break   (m_is_break),
        .m_event_time (m_event_time),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [CODE_W-1:0] code_at(input logic [WORD_W-1:0] w,
                                                 input int unsigned s);
        if (s >= WORD_SLOTS) begin
            return '0;
        end
        return w[CODE_W*s +: CODE_W];
    endfunction

    function automatic bit code_present(input logic [WORD_W-1:0] w,
                                        input logic [CODE_W-1:0] code);
        bit hit;
        hit = 1'b0;
        for (int unsigned s = 0; s < SLOTS; s++) begin
            if (code_at(w, s) == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // advance the debounce state by one scan tick and queue the events it yields
    task automatic debounce_tick(input scan_tick_t t);
        key_event_t        ev;
        key_event_t        evs[$];
        logic [CODE_W-1:0] c;
        if (t.sample != held_word) begin
            held_word  = t.sample;
            stable_cnt = '0;
        end else if (stable_cnt < {1'b0, limit_reg}) begin
            stable_cnt = stable_cnt + COUNT_STEP;
        end
        if (shown_word != held_word && stable_cnt >= {1'b0, limit_reg}) begin
            for (int unsigned s = 0; s < SLOTS; s++) begin
                c = code_at(held_word, s);
                if (c != '0 && !code_present(shown_word, c)) begin
                    ev.code  = c;
                    ev.brk   = 1'b0;
                    ev.stamp = t.stamp;
                    ev.fin   = 1'b0;
                    evs.push_back(ev);
                end
            end
            for (int unsigned s = 0; s < SLOTS; s++) begin
                c = code_at(shown_word, s);
                if (c != '0 && !code_present(held_word, c)) begin
                    ev.code  = c;
                    ev.brk   = 1'b1;
                    ev.stamp = t.stamp;
                    ev.fin   = 1'b0;
                    evs.push_back(ev);
                end
            end
            if (evs.size() != 0) begin
                ev     = evs.pop_back();
                ev.fin = 1'b1;
                evs.push_back(ev);
            end
            foreach (evs[i]) begin
                event_q.push_back(evs[i]);
            end
            shown_word = held_word;
        end
    endtask

    task automatic report(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // monitor: predict on accepted ticks, then check accepted events
    always @(posedge aclk) begin : monitor
        key_event_t want;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_fire) begin
            debounce_tick({s_key_sample, s_timestamp});
            ticks_taken++;
        end
        if (m_fire) begin
            if (event_q.size() == 0) begin
                report($sformatf("unexpected event code=%02h break=%0b time=%08h last=%0b",
                                 m_key_code, m_is_break, m_event_time, m_last));
            end else begin
                want = event_q.pop_front();
                if (m_key_code != want.code || m_is_break != want.brk
                        || m_event_time != want.stamp || m_last != want.fin) begin
                    report($sformatf("got code=%02h break=%0b time=%08h last=%0b, want %02h %0b %08h %0b",
                                     m_key_code, m_is_break, m_event_time, m_last,
                                     want.code, want.brk, want.stamp, want.fin));
                end
            end
        end
        if (s_fire || m_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // tick driver
    always @(negedge aclk) begin : driver
        scan_tick_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (scan_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt          = scan_q.pop_front();
                s_valid      <= 1'b1;
                s_key_sample <= nxt.sample;
                s_timestamp  <= nxt.stamp;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // event receiver, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && ticks_taken >= HOLD_AFTER && m_valid) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic add_tick(input logic [WORD_W-1:0] w, input logic [STAMP_W-1:0] stamp);
        scan_tick_t t;
        t.sample = w;
        t.stamp  = stamp;
        scan_q.push_back(t);
    endtask

    task automatic add_random_tick(input logic [WORD_W-1:0] w);
        case ($urandom_range(0, 19))
            0:       add_tick(w, '0);
            1:       add_tick(w, '1);
            default: add_tick(w, $urandom);
        endcase
    endtask

    // wait until the block has nothing left to do
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (scan_q.size() != 0 || s_valid || event_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        limit_reg = v;
    endtask

    function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] prev);
        logic [WORD_W-1:0] w;
        int unsigned       s;
        w = prev;
        s = $urandom_range(0, WORD_SLOTS - 1);
        case ($urandom_range(0, 5))
            0: w = $urandom;
            1: w = {prev[WORD_W-CODE_W-1:0], prev[WORD_W-1:WORD_W-CODE_W]};
            2: w[CODE_W*s +: CODE_W] = CODE_W'($urandom_range(1, 6));
            3: w[CODE_W*s +: CODE_W] = '0;
            default: begin
                for (int unsigned k = 0; k < WORD_SLOTS; k++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: w[CODE_W*k +: CODE_W] = '0;
                        9:          w[CODE_W*k +: CODE_W] = CODE_W'($urandom);
                        default:    w[CODE_W*k +: CODE_W] = CODE_W'($urandom_range(1, 6));
                    endcase
                end
            end
        endcase
        return w;
    endfunction

    initial begin : stimulus
        logic [WORD_W-1:0]  w;
        logic [LIMIT_W-1:0] lim;
        int unsigned        budget;
        int unsigned        n;
        int unsigned        reps;
        int unsigned        base;
        int unsigned        r;
        w = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // zero limit: events on the tick of the change
        add_tick(32'h0000_0000, 32'h0000_0000);
        add_tick(32'h0403_0201, 32'hffff_ffff);
        add_tick(32'h0102_0304, 32'h0000_0001);
        add_tick(32'h0807_0605, 32'h0000_0002);
        add_tick(32'h0000_0000, 32'h0000_0003);
        add_tick(32'hffff_ffff, 32'h8000_0000);
        add_tick(32'h0000_00ff, 32'h7fff_ffff);
        add_tick(32'h1122_3344, 32'h0000_0004);
        add_tick(32'h1122_0044, 32'h0000_0005);
        add_tick(32'h00ff_0000, 32'h0000_0006);
        drain();

        // debounce, then a bounce that settles back on the reported word
        set_limit(16'd20);
        add_tick(32'h0000_00aa, 32'h0000_0010);
        add_tick(32'h0000_00aa, 32'h0000_0011);
        add_tick(32'h0000_00aa, 32'h0000_0012);
        add_tick(32'h0000_00aa, 32'h0000_0013);
        add_tick(32'h0000_bb00, 32'h0000_0014);
        add_tick(32'h0000_00aa, 32'h0000_0015);
        add_tick(32'h0000_00aa, 32'h0000_0016);
        drain();

        set_limit(16'hffff);
        add_tick(32'h0000_5555, 32'h0000_0020);
        add_tick(32'h0000_5555, 32'h0000_0021);
        add_tick(32'h0000_5555, 32'h0000_0022);
        drain();

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            lim = PHASE_LIMITS[LIMIT_W*p +: LIMIT_W];
            set_limit(lim);
            steady = (p == 5);
            budget = (lim == 16'hffff) ? 20 : 45;
            base   = (int'(lim) + 9) / 10;
            n      = 0;
            while (n < budget) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    add_random_tick($urandom);
                    n++;
                end else begin
                    w = next_word(w);
                    if (lim == 16'hffff) begin
                        reps = $urandom_range(1, 4);
                    end else if (r == 1) begin
                        reps = $urandom_range(1, (base > 0) ? base : 1);
                    end else begin
                        reps = base + 1 + $urandom_range(0, 1);
                    end
                    repeat (reps) add_random_tick(w);
                    n += reps;
                end
            end
            drain();
            steady = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
